@@ rtl/core/ctach_pkg.sv @@
package ctach_pkg;

	// widths fixed by the request and result fields
	localparam int TIMER_BITS = 16;
	localparam int CHANNELS   = 2;
	localparam int CH_BITS    = $clog2(CHANNELS);
	localparam int NUMER_BITS = 24;
	localparam int TOTAL_BITS = 32;
	localparam int STEP_BITS  = $clog2(NUMER_BITS);

	localparam logic [NUMER_BITS-1:0] NUMER_RESET = NUMER_BITS'(2000000);
	localparam logic [STEP_BITS-1:0]  LAST_STEP   = STEP_BITS'(NUMER_BITS - 1);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} ctach_state_t;

endpackage

@@ rtl/core/capture_tachometer.sv @@
// Two-channel edge-capture tachometer. Each request carries a channel number
// and the 16-bit timer value latched at a wheel edge; the block returns the
// period since the previous edge on that channel (modulo 2^16), the wrapping
// 32-bit edge count of that channel and speed = rpm_numerator / period. A zero
// period, as on the first edge after reset with a capture of zero, gives an
// all-ones speed with zero_period set. Once a request is accepted, a
// restoring divider produces one quotient bit a cycle over 24 steps, then the
// output register is loaded. The sequencer returns to idle with that load and
// accepts requests only in idle, so a new request waits until the previous
// result is loaded; a finished result that finds the output register still
// holding a stalled result waits in the divider and holds off new requests.
// rpm_numerator is written through cfg_write/cfg_data and resets to 2000000.
module capture_tachometer
	import ctach_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_write,
	input  logic [NUMER_BITS-1:0] cfg_data,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CH_BITS-1:0]    channel,
	input  logic [TIMER_BITS-1:0] capture_time,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [CH_BITS-1:0]    result_channel,
	output logic [TIMER_BITS-1:0] edge_period,
	output logic [TOTAL_BITS-1:0] edge_total,
	output logic [NUMER_BITS-1:0] speed,
	output logic                  zero_period
);

	ctach_state_t state_q, state_d;

	logic [NUMER_BITS-1:0] numer_q;
	logic [TIMER_BITS-1:0] last_capture_q [CHANNELS];
	logic [TOTAL_BITS-1:0] edge_counter_q [CHANNELS];

	logic [CH_BITS-1:0]    ch_q;
	logic [TIMER_BITS-1:0] period_q;
	logic [TOTAL_BITS-1:0] total_q;
	logic [TIMER_BITS-1:0] rem_q;
	logic [NUMER_BITS-1:0] quo_q;
	logic [STEP_BITS-1:0]  step_q;

	logic                  out_valid_q;
	logic [CH_BITS-1:0]    out_ch_q;
	logic [TIMER_BITS-1:0] out_period_q;
	logic [TOTAL_BITS-1:0] out_total_q;
	logic [NUMER_BITS-1:0] out_speed_q;
	logic                  out_zero_q;

	logic                  req_take;
	logic                  out_free;
	logic                  out_load;
	logic [TIMER_BITS-1:0] period_new;
	logic [TIMER_BITS:0]   trial;
	logic [TIMER_BITS:0]   shifted;

	// request period, modulo 2^TIMER_BITS
	assign period_new = capture_time - last_capture_q[channel];

	// one restoring divide step
	assign shifted = {rem_q, quo_q[NUMER_BITS-1]};
	assign trial   = shifted - {1'b0, period_q};

	assign out_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (step_q == LAST_STEP) state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:   in_stall = 1'b0;
			ST_DIVIDE: in_stall = 1'b1;
			ST_HOLD:   out_load = out_free;
			default:   in_stall = 1'b1;
		endcase
	end

	assign req_take = in_valid && !in_stall;

	// state, configuration and per-channel history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			numer_q     <= NUMER_RESET;
			out_valid_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_capture_q[i] <= '0;
				edge_counter_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_write) numer_q <= cfg_data;
			if (req_take) begin
				last_capture_q[channel] <= capture_time;
				edge_counter_q[channel] <= edge_counter_q[channel] + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (req_take) begin
			ch_q     <= channel;
			period_q <= period_new;
			total_q  <= edge_counter_q[channel] + 1'b1;
			rem_q    <= '0;
			quo_q    <= numer_q;
			step_q   <= '0;
		end else if (state_q == ST_DIVIDE) begin
			if (trial[TIMER_BITS]) begin
				rem_q <= shifted[TIMER_BITS-1:0];
			end else begin
				rem_q <= trial[TIMER_BITS-1:0];
			end
			quo_q  <= {quo_q[NUMER_BITS-2:0], !trial[TIMER_BITS]};
			step_q <= step_q + 1'b1;
		end
	end

	// output register, zero period saturates speed
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_ch_q     <= ch_q;
			out_period_q <= period_q;
			out_total_q  <= total_q;
			out_zero_q   <= (period_q == '0);
			out_speed_q  <= (period_q == '0) ? '1 : quo_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_channel = out_ch_q;
	assign edge_period    = out_period_q;
	assign edge_total     = out_total_q;
	assign speed          = out_speed_q;
	assign zero_period    = out_zero_q;

endmodule

@@ sim/testbench.sv @@
module testbench;
	import ctach_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASES      = 8;
	localparam int PHASE_EDGES = 106;
	localparam int SETTLE      = 40;

	// one expected tachometer reading
	typedef struct {
		logic [CH_BITS-1:0]    chan;
		logic [TIMER_BITS-1:0] period;
		logic [TOTAL_BITS-1:0] total;
		logic [NUMER_BITS-1:0] rate;
		logic                  saturated;
	} edge_result_t;

	// per-channel wheel state and the queue of readings still owed by the block
	class tach_scoreboard;
		edge_result_t          readings_q[$];
		logic [NUMER_BITS-1:0] numerator;
		logic [TIMER_BITS-1:0] prev_capture [CHANNELS];
		logic [TOTAL_BITS-1:0] edge_count [CHANNELS];
		int                    errors;

		function new();
			numerator = NUMER_RESET;
			errors = 0;
			for (int i = 0; i < CHANNELS; i++) begin
				prev_capture[i] = '0;
				edge_count[i] = '0;
			end
		endfunction

		function void set_numerator(logic [NUMER_BITS-1:0] value);
			numerator = value;
		endfunction

		function int pending();
			return readings_q.size();
		endfunction

		// accepted request: derive period, count and speed for that wheel
		function void note_edge(logic [CH_BITS-1:0] ch, logic [TIMER_BITS-1:0] cap);
			edge_result_t r;
			logic [TIMER_BITS-1:0] ticks;
			ticks = cap - prev_capture[ch];
			prev_capture[ch] = cap;
			edge_count[ch] = edge_count[ch] + 1'b1;
			r.chan = ch;
			r.period = ticks;
			r.total = edge_count[ch];
			if (ticks == '0) begin
				// stalled wheel or repeated timestamp: speed pinned high
				r.rate = '1;
				r.saturated = 1'b1;
			end else begin
				r.rate = numerator / ticks;
				r.saturated = 1'b0;
			end
			readings_q.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [CH_BITS-1:0] ch, logic [TIMER_BITS-1:0] period,
				logic [TOTAL_BITS-1:0] total, logic [NUMER_BITS-1:0] rate, logic saturated);
			edge_result_t want;
			if (readings_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, %s %0d %0h %0h %0h %0b",
					$time, "actual ch/period/total/speed/zero", ch, period, total, rate,
					saturated);
				return;
			end
			want = readings_q.pop_front();
			compare_field("result_channel", 64'(want.chan), 64'(ch));
			compare_field("edge_period", 64'(want.period), 64'(period));
			compare_field("edge_total", 64'(want.total), 64'(total));
			compare_field("speed", 64'(want.rate), 64'(rate));
			compare_field("zero_period", 64'(want.saturated), 64'(saturated));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [NUMER_BITS-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [CH_BITS-1:0]    channel;
	logic [TIMER_BITS-1:0] capture_time;
	logic                  out_valid;
	logic                  out_stall;
	logic [CH_BITS-1:0]    result_channel;
	logic [TIMER_BITS-1:0] edge_period;
	logic [TOTAL_BITS-1:0] edge_total;
	logic [NUMER_BITS-1:0] speed;
	logic                  zero_period;

	tach_scoreboard        board;
	logic [TIMER_BITS-1:0] wheel_time [CHANNELS];
	bit                    src_quiet;
	bit                    sink_quiet;
	int                    holds_wanted;
	int                    holds_done;
	int                    hold_left;
	int                    cycle_count;

	capture_tachometer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.capture_time   (capture_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_channel (result_channel),
		.edge_period    (edge_period),
		.edge_total     (edge_total),
		.speed          (speed),
		.zero_period    (zero_period)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	// result side: random stalls, plus a long hold-off when one is asked for
	always @(negedge clk) begin
		if (holds_wanted != holds_done) begin
			holds_done = holds_wanted;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !sink_quiet && ($urandom_range(99) < 25);
		end
	end

	// check every result taken from the block
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(result_channel, edge_period, edge_total, speed, zero_period);
	end

	// offer one edge request and hold it until taken
	task automatic send_edge(input logic [CH_BITS-1:0] ch, input logic [TIMER_BITS-1:0] cap);
		in_valid <= 1'b1;
		channel <= ch;
		capture_time <= cap;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_edge(ch, cap);
		wheel_time[ch] = cap;
		@(negedge clk);
	endtask

	// random gap on the request side
	task automatic sender_pause();
		int idle_len;
		if (src_quiet || $urandom_range(99) >= 25)
			return;
		idle_len = $urandom_range(1, 30);
		in_valid <= 1'b0;
		repeat (idle_len) @(negedge clk);
	endtask

	// new numerator, written only once every reading is back
	task automatic load_numerator(input logic [NUMER_BITS-1:0] value);
		in_valid <= 1'b0;
		while (board.pending() != 0)
			@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= value;
		board.set_numerator(value);
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// mostly plausible wheel timing, some repeats and some arbitrary stamps
	function automatic logic [TIMER_BITS-1:0] next_capture(input logic [CH_BITS-1:0] ch);
		case ($urandom_range(9))
			0: return wheel_time[ch];
			1, 2, 3: return TIMER_BITS'($urandom);
			default: return wheel_time[ch] + TIMER_BITS'($urandom_range(1, 3000));
		endcase
	endfunction

	initial begin
		logic [NUMER_BITS-1:0] numer;
		board = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		channel = '0;
		capture_time = '0;
		out_stall = 1'b0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;
		holds_wanted = 0;
		holds_done = 0;
		hold_left = 0;
		cycle_count = 0;
		for (int i = 0; i < CHANNELS; i++)
			wheel_time[i] = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset numerator: first edges, wrap, repeated stamps
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, 16'h0001);
		send_edge(1'b0, 16'hFFFF);
		send_edge(1'b0, 16'h0000);
		send_edge(1'b1, 16'h0001);
		send_edge(1'b1, 16'h8000);
		send_edge(1'b1, 16'h0000);
		send_edge(1'b0, 16'h5555);
		send_edge(1'b0, 16'hAAAA);
		send_edge(1'b1, 16'h07D0);
		send_edge(1'b0, 16'hAAAA);

		// largest numerator: full-scale quotient without the zero flag
		load_numerator('1);
		send_edge(1'b0, 16'hAAAB);
		send_edge(1'b1, 16'h07D1);
		send_edge(1'b0, 16'h2AAA);
		send_edge(1'b1, 16'h07D0);

		// smallest numerator
		load_numerator(NUMER_BITS'(1));
		send_edge(1'b0, 16'h2AAB);
		send_edge(1'b1, 16'h07D2);
		send_edge(1'b1, 16'h07D2);

		// zero numerator
		load_numerator('0);
		send_edge(1'b0, 16'h2AAC);
		send_edge(1'b1, 16'hFFFF);
		send_edge(1'b0, 16'h2AAC);

		// random phases, each under its own numerator
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1: numer = '1;
				2: numer = NUMER_BITS'(1);
				3: numer = '0;
				5: numer = NUMER_RESET;
				7: numer = NUMER_BITS'($urandom_range(2, 5000));
				default: numer = NUMER_BITS'($urandom);
			endcase
			load_numerator(numer);
			src_quiet = (phase == 3);
			sink_quiet = (phase == 3);
			for (int n = 0; n < PHASE_EDGES; n++) begin
				logic [CH_BITS-1:0] ch;
				if (phase == 1 && n == 10)
					holds_wanted = holds_wanted + 1;
				ch = CH_BITS'($urandom_range(CHANNELS - 1));
				send_edge(ch, next_capture(ch));
				sender_pause();
			end
		end
		in_valid <= 1'b0;
		src_quiet = 1'b0;
		sink_quiet = 1'b0;

		// drain, then give the divider time to show anything spurious
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/ctach_pkg.sv
rtl/core/capture_tachometer.sv
sim/testbench.sv
